// File: hw/rtl/marker_tracking_speed_estimator_core_macros.svh
// Assertion helpers shared by the block.
`ifndef MARKER_TRACKING_SPEED_ESTIMATOR_CORE_MACROS_SVH
`define MARKER_TRACKING_SPEED_ESTIMATOR_CORE_MACROS_SVH

// same-cycle implication
`define MTSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtse check failed");

// next-cycle implication
`define MTSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtse check failed");

`endif

// File: hw/rtl/mtse_pkg.sv
package mtse_pkg;

	localparam int MARKER_COUNT = 4;
	localparam int IDX_W = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;
	localparam int SUM_W = 32 + $clog2(MARKER_COUNT);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_XX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FPS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INV_RADII = 3'd7;

	localparam int ROOT_STEPS = 50;
	localparam int DIV_STEPS = 60;
	localparam int CNT_W = 6;

	typedef enum logic [3:0] {
		OP_WX_A   = 4'd0,
		OP_WX_B   = 4'd1,
		OP_WY_A   = 4'd2,
		OP_WY_B   = 4'd3,
		OP_SQX_LL = 4'd4,
		OP_SQX_HL = 4'd5,
		OP_SQX_HH = 4'd6,
		OP_SQY_LL = 4'd7,
		OP_SQY_HL = 4'd8,
		OP_SQY_HH = 4'd9,
		OP_DF_LO  = 4'd10,
		OP_DF_HI  = 4'd11,
		OP_Q_LO   = 4'd12,
		OP_Q_HI   = 4'd13
	} op_t;

	typedef struct packed {
		logic load;
		logic match;
		logic mul;
		logic acc;
		op_t  op;
		logic sqrt_step;
		logic div_step;
		logic wb;
		logic sum;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic priming;
		logic gap_zero;
		logic last;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/mtse_if.sv
interface mtse_det_if;
	logic        valid;
	logic        ready;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [1:0]  slot;
	logic [15:0] frame_gap;
	logic        last_in_frame;

	modport source(output valid, pos_x, pos_y, slot, frame_gap, last_in_frame, input ready);
	modport sink(input valid, pos_x, pos_y, slot, frame_gap, last_in_frame, output ready);
endinterface

interface mtse_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] mean_rate;
	logic        priming;

	modport source(output valid, mean_rate, priming, input ready);
	modport sink(input valid, mean_rate, priming, output ready);
endinterface

// File: hw/rtl/mtse_ctrl.sv
module mtse_ctrl import mtse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_MATCH, S_MUL, S_ACC, S_SQRT, S_DIV, S_WB, S_SUM, S_OUT
	} state_t;

	state_t state_q;
	op_t op_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_MATCH: cmd.match = 1'b1;
			S_MUL:   cmd.mul = 1'b1;
			S_ACC:   cmd.acc = 1'b1;
			S_SQRT:  cmd.sqrt_step = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_WB:    cmd.wb = 1'b1;
			S_SUM:   cmd.sum = 1'b1;
			S_OUT:   cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_WX_A;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MATCH;
				S_MATCH: begin
					if (sts.priming || sts.gap_zero) begin
						state_q <= sts.last ? S_SUM : S_IDLE;
					end else begin
						op_q <= OP_WX_A;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					cnt_q <= '0;
					if (op_q == OP_SQY_HH) begin
						state_q <= S_SQRT;
					end else if (op_q == OP_DF_HI) begin
						state_q <= S_DIV;
					end else if (op_q == OP_Q_HI) begin
						state_q <= S_WB;
					end else begin
						op_q <= op_t'(op_q + 4'd1);
						state_q <= S_MUL;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
						op_q <= OP_DF_LO;
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						op_q <= OP_Q_LO;
						state_q <= S_MUL;
					end
				end
				S_WB: state_q <= sts.last ? S_SUM : S_IDLE;
				S_SUM: state_q <= S_OUT;
				S_OUT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/mtse_datapath.sv
module mtse_datapath import mtse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [15:0]           pos_x,
	input  logic [15:0]           pos_y,
	input  logic [1:0]            slot,
	input  logic [15:0]           frame_gap,
	input  logic                  last_in_frame,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           mean_rate,
	output logic                  priming
);

	logic signed [31:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
	logic [9:0]  fps_q;
	logic [63:0] inv_q;

	logic [15:0] x_q, y_q, gap_q;
	logic [1:0]  slot_q;
	logic        last_q, wasprim_q, primed_q;

	logic [15:0] prev_x_q [MARKER_COUNT];
	logic [15:0] prev_y_q [MARKER_COUNT];
	logic [31:0] rate_q   [MARKER_COUNT];
	logic [IDX_W-1:0] best_q;

	logic signed [16:0] ddx_q, ddy_q;
	logic signed [67:0] p_q;
	logic signed [49:0] w_q;
	logic [48:0]  ax_q, ay_q;
	logic [99:0]  rad_q;
	logic [51:0]  rem_q;
	logic [49:0]  root_q;
	logic [59:0]  num_q;
	logic [15:0]  drem_q;
	logic [75:0]  prod_q;

	logic        out_valid_q, out_prim_q;
	logic [31:0] out_rate_q;

	// nearest stored marker, own slot first, strict improvement only
	logic [IDX_W-1:0] best_c;
	logic [16:0]      d_c [MARKER_COUNT];
	logic [16:0]      bestd_c;
	logic             slot_ok;

	always_comb begin
		slot_ok = (32'(slot_q) < 32'(MARKER_COUNT));
		for (int k = 0; k < MARKER_COUNT; k++) begin
			d_c[k] = 17'(((x_q > prev_x_q[k]) ? x_q - prev_x_q[k] : prev_x_q[k] - x_q))
				+ 17'(((y_q > prev_y_q[k]) ? y_q - prev_y_q[k] : prev_y_q[k] - y_q));
		end
		best_c = slot_ok ? slot_q[IDX_W-1:0] : '0;
		bestd_c = d_c[best_c];
		for (int k = 0; k < MARKER_COUNT; k++) begin
			if (d_c[k] < bestd_c) begin
				bestd_c = d_c[k];
				best_c = IDX_W'(k);
			end
		end
	end

	// shared multiplier operands
	logic signed [33:0] ma, mb;
	logic [15:0] inv_sel;

	assign inv_sel = inv_q[16*int'(best_q) +: 16];

	always_comb begin
		case (cmd.op)
			OP_WX_A: begin
				ma = {{2{coef_xx_q[31]}}, coef_xx_q};
				mb = {{17{ddx_q[16]}}, ddx_q};
			end
			OP_WX_B: begin
				ma = {{2{coef_xy_q[31]}}, coef_xy_q};
				mb = {{17{ddy_q[16]}}, ddy_q};
			end
			OP_WY_A: begin
				ma = {{2{coef_yx_q[31]}}, coef_yx_q};
				mb = {{17{ddx_q[16]}}, ddx_q};
			end
			OP_WY_B: begin
				ma = {{2{coef_yy_q[31]}}, coef_yy_q};
				mb = {{17{ddy_q[16]}}, ddy_q};
			end
			OP_SQX_LL: begin
				ma = {9'b0, ax_q[24:0]};
				mb = {9'b0, ax_q[24:0]};
			end
			OP_SQX_HL: begin
				ma = {10'b0, ax_q[48:25]};
				mb = {9'b0, ax_q[24:0]};
			end
			OP_SQX_HH: begin
				ma = {10'b0, ax_q[48:25]};
				mb = {10'b0, ax_q[48:25]};
			end
			OP_SQY_LL: begin
				ma = {9'b0, ay_q[24:0]};
				mb = {9'b0, ay_q[24:0]};
			end
			OP_SQY_HL: begin
				ma = {10'b0, ay_q[48:25]};
				mb = {9'b0, ay_q[24:0]};
			end
			OP_SQY_HH: begin
				ma = {10'b0, ay_q[48:25]};
				mb = {10'b0, ay_q[48:25]};
			end
			OP_DF_LO: begin
				ma = {9'b0, root_q[24:0]};
				mb = {24'b0, fps_q};
			end
			OP_DF_HI: begin
				ma = {9'b0, root_q[49:25]};
				mb = {24'b0, fps_q};
			end
			OP_Q_LO: begin
				ma = {4'b0, num_q[29:0]};
				mb = {18'b0, inv_sel};
			end
			OP_Q_HI: begin
				ma = {4'b0, num_q[59:30]};
				mb = {18'b0, inv_sel};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	logic signed [49:0] wsum, wabs;
	assign wsum = w_q + p_q[49:0];
	assign wabs = wsum[49] ? -wsum : wsum;

	logic [51:0] sq_rem, sq_trial;
	assign sq_rem = {rem_q[49:0], rad_q[99:98]};
	assign sq_trial = {root_q, 2'b01};

	logic [16:0] dv_t, dv_d;
	assign dv_t = {drem_q, num_q[59]};
	assign dv_d = {1'b0, gap_q};

	logic [SUM_W-1:0] sum_c;
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < MARKER_COUNT; k++) sum_c = sum_c + SUM_W'(rate_q[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q <= 32'sd65536;
			coef_xy_q <= '0;
			coef_yx_q <= '0;
			coef_yy_q <= 32'sd65536;
			fps_q <= 10'd100;
			inv_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_COEF_XX:   coef_xx_q <= cfg_wdata[31:0];
				REG_COEF_XY:   coef_xy_q <= cfg_wdata[31:0];
				REG_COEF_YX:   coef_yx_q <= cfg_wdata[31:0];
				REG_COEF_YY:   coef_yy_q <= cfg_wdata[31:0];
				REG_FPS:       fps_q <= cfg_wdata[9:0];
				REG_INV_RADII: inv_q <= cfg_wdata;
				// offsets cancel in the displacement; drop them
				REG_OFFSET_X, REG_OFFSET_Y: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MARKER_COUNT; k++) begin
				prev_x_q[k] <= '0;
				prev_y_q[k] <= '0;
				rate_q[k] <= '0;
			end
		end else begin
			if (cmd.match) begin
				if (wasprim_q) begin
					if (slot_ok) begin
						prev_x_q[slot_q[IDX_W-1:0]] <= x_q;
						prev_y_q[slot_q[IDX_W-1:0]] <= y_q;
					end
					if (last_q) primed_q <= 1'b1;
				end else begin
					prev_x_q[best_c] <= x_q;
					prev_y_q[best_c] <= y_q;
				end
			end
			if (cmd.wb) begin
				rate_q[best_q] <= (|prod_q[75:52]) ? 32'hFFFF_FFFF : prod_q[51:20];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= pos_x;
			y_q <= pos_y;
			slot_q <= slot;
			gap_q <= frame_gap;
			last_q <= last_in_frame;
			wasprim_q <= !primed_q;
		end
		if (cmd.match) begin
			best_q <= best_c;
			ddx_q <= 17'({1'b0, x_q}) - 17'({1'b0, prev_x_q[best_c]});
			ddy_q <= 17'({1'b0, y_q}) - 17'({1'b0, prev_y_q[best_c]});
		end
		if (cmd.mul) p_q <= ma * mb;
		if (cmd.acc) begin
			case (cmd.op)
				OP_WX_A, OP_WY_A: w_q <= p_q[49:0];
				OP_WX_B: ax_q <= wabs[48:0];
				OP_WY_B: ay_q <= wabs[48:0];
				OP_SQX_LL: begin
					rad_q <= 100'(p_q[49:0]);
					rem_q <= '0;
					root_q <= '0;
				end
				OP_SQX_HL, OP_SQY_HL: rad_q <= rad_q + (100'(p_q[49:0]) << 26);
				OP_SQX_HH, OP_SQY_HH: rad_q <= rad_q + (100'(p_q[49:0]) << 50);
				OP_SQY_LL: rad_q <= rad_q + 100'(p_q[49:0]);
				OP_DF_LO: begin
					num_q <= 60'(p_q[59:0]);
					drem_q <= '0;
				end
				OP_DF_HI: num_q <= num_q + (60'(p_q[59:0]) << 25);
				OP_Q_LO: prod_q <= 76'(p_q[67:0]);
				OP_Q_HI: prod_q <= prod_q + (76'(p_q[67:0]) << 30);
				default: ;
			endcase
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[97:0], 2'b00};
			if (sq_rem >= sq_trial) begin
				rem_q <= sq_rem - sq_trial;
				root_q <= {root_q[48:0], 1'b1};
			end else begin
				rem_q <= sq_rem;
				root_q <= {root_q[48:0], 1'b0};
			end
		end
		// marker count is a power of two, so the mean is a shift
		if (cmd.sum) begin
			num_q <= 60'(sum_c / SUM_W'(MARKER_COUNT));
		end
		if (cmd.div_step) begin
			if (dv_t >= dv_d) begin
				drem_q <= 16'(dv_t - dv_d);
				num_q <= {num_q[58:0], 1'b1};
			end else begin
				drem_q <= dv_t[15:0];
				num_q <= {num_q[58:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_rate_q <= num_q[31:0];
			out_prim_q <= wasprim_q;
		end
	end

	assign sts.priming = wasprim_q;
	assign sts.gap_zero = (gap_q == '0);
	assign sts.last = last_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign mean_rate = out_rate_q;
	assign priming = out_prim_q;

endmodule

// File: hw/rtl/marker_tracking_speed_estimator_core.sv
// Marker speed estimator.
// det carries one marker detection per transfer (position, slot, frame gap,
// last-of-frame mark); res carries one mean rate per frame, on the transfer
// that had last_in_frame set. cfg_we/cfg_addr/cfg_wdata write the settings,
// which the user must do only while the block is idle; the block leaves it unchecked.
// One detection at a time: det.ready is high only when the sequencer is idle.
// A priming or zero-gap detection only stores its position; a matched one runs
// 14 multiply/accumulate pairs on the shared 34x34 multiplier, 50 root steps
// and 60 quotient steps of the shift-subtract divider. A last detection then
// sums the rates and shifts them down, then loads the result once the output is free.
// The result sits in an output register, so the next detection is taken
// while res waits; a second result waits until the first is taken.
// Reset clears stored positions, rates, the primed flag and the settings to
// their defaults; the first frame after reset only stores positions.
`include "marker_tracking_speed_estimator_core_macros.svh"
module marker_tracking_speed_estimator_core import mtse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mtse_det_if.sink              det,
	mtse_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	mtse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (det.valid),
		.in_ready (det.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtse_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.pos_x         (det.pos_x),
		.pos_y         (det.pos_y),
		.slot          (det.slot),
		.frame_gap     (det.frame_gap),
		.last_in_frame (det.last_in_frame),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (res.valid),
		.out_ready     (res.ready),
		.mean_rate     (res.mean_rate),
		.priming       (res.priming)
	);

	`MTSE_ASSERT_NEXT(a_busy_after_take, clk, arst_n, det.valid && det.ready, !det.ready)
	`MTSE_ASSERT_NOW(a_load_on_valid, clk, arst_n, cmd.load, det.valid && det.ready)
	`MTSE_ASSERT_NOW(a_out_load_free, clk, arst_n, cmd.out_load, !res.valid || res.ready)

endmodule

// File: tb/marker_tracking_speed_estimator_core_tb.sv
module marker_tracking_speed_estimator_core_tb;
	import mtse_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 310;
	localparam int PHASES = 6;

	typedef struct {
		logic [31:0] mean_rate;
		logic        priming;
	} frame_rate_t;

	typedef struct {
		int          pre_cfg;
		logic [15:0] x;
		logic [15:0] y;
		logic [1:0]  slot;
		logic [15:0] gap;
		bit          last;
		bit          typed;
		logic [31:0] t_mean;
		bit          t_prim;
	} det_row_t;

	localparam int CFG_NONE = 0;
	localparam int CFG_EXTREME = 1;
	localparam int CFG_ZERO_FPS = 2;
	localparam int CFG_MIN_FPS = 3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mtse_det_if det_if();
	mtse_res_if res_if();

	marker_tracking_speed_estimator_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.det(det_if),
		.res(res_if),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// settings mirror
	longint m_cxx, m_cxy, m_cyx, m_cyy;
	logic [9:0]  m_fps;
	logic [63:0] m_inv;

	// tracker state mirror
	logic [15:0] trk_x[MARKER_COUNT];
	logic [15:0] trk_y[MARKER_COUNT];
	logic [31:0] trk_rate[MARKER_COUNT];
	bit          trk_primed;

	frame_rate_t rate_q[$];
	det_row_t    dir_rows[$];
	int          errors;
	longint      cycles;
	int          burst_left;
	int          stall_left;
	int          run_left;
	bit          typed_on;
	logic [31:0] typed_mean;
	bit          typed_prim;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [31:0] marker_speed(input int k, input logic [15:0] ox,
			input logic [15:0] oy, input logic [15:0] nx, input logic [15:0] ny,
			input logic [15:0] gap);
		longint ddx, ddy, wx, wy;
		logic [63:0] ax, ay, root, cand, q;
		logic [127:0] sq, cc, prod;
		logic [15:0] inv;
		ddx = longint'(nx) - longint'(ox);
		ddy = longint'(ny) - longint'(oy);
		wx = m_cxx * ddx + m_cxy * ddy;
		wy = m_cyx * ddx + m_cyy * ddy;
		ax = (wx < 0) ? 64'(-wx) : 64'(wx);
		ay = (wy < 0) ? 64'(-wy) : 64'(wy);
		sq = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
		root = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			cc = {64'd0, cand} * {64'd0, cand};
			if (cc <= sq)
				root = cand;
		end
		q = (root * 64'(m_fps)) / 64'(gap);
		inv = m_inv[16*k +: 16];
		prod = {64'd0, q} * {112'd0, inv};
		prod = prod >> 20;
		return (prod > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
	endfunction

	task automatic track_detection(input logic [15:0] x, input logic [15:0] y,
			input logic [1:0] slot, input logic [15:0] gap, input bit last,
			output bit has, output frame_rate_t fr);
		bit was_priming;
		int best;
		logic [16:0] bestd, d;
		logic [15:0] ox, oy;
		logic [33:0] sum;
		was_priming = !trk_primed;
		if (was_priming) begin
			trk_x[slot] = x;
			trk_y[slot] = y;
			if (last)
				trk_primed = 1'b1;
		end else begin
			best = slot;
			bestd = 17'((x > trk_x[best]) ? x - trk_x[best] : trk_x[best] - x)
				+ 17'((y > trk_y[best]) ? y - trk_y[best] : trk_y[best] - y);
			for (int k = 0; k < MARKER_COUNT; k++) begin
				d = 17'((x > trk_x[k]) ? x - trk_x[k] : trk_x[k] - x)
					+ 17'((y > trk_y[k]) ? y - trk_y[k] : trk_y[k] - y);
				if (d < bestd) begin
					bestd = d;
					best = k;
				end
			end
			ox = trk_x[best];
			oy = trk_y[best];
			trk_x[best] = x;
			trk_y[best] = y;
			// zero gap: hold the stored rate
			if (gap != 16'd0)
				trk_rate[best] = marker_speed(best, ox, oy, x, y, gap);
		end
		has = last;
		sum = '0;
		for (int k = 0; k < MARKER_COUNT; k++)
			sum += 34'(trk_rate[k]);
		fr.mean_rate = 32'(sum / MARKER_COUNT);
		fr.priming = was_priming;
	endtask

	// transfer monitors
	always @(posedge clk) begin
		bit has;
		frame_rate_t fr, want;
		if (arst_n) begin
			if (det_if.valid && det_if.ready) begin
				track_detection(det_if.pos_x, det_if.pos_y, det_if.slot, det_if.frame_gap,
					det_if.last_in_frame, has, fr);
				if (has) begin
					if (typed_on) begin
						fr.mean_rate = typed_mean;
						fr.priming = typed_prim;
					end
					rate_q.push_back(fr);
				end
			end
			if (res_if.valid && res_if.ready) begin
				if (rate_q.size() == 0) begin
					report_mismatch("unexpected result", res_if.mean_rate, 32'd0);
				end else begin
					want = rate_q.pop_front();
					if (res_if.mean_rate !== want.mean_rate)
						report_mismatch("mean_rate", res_if.mean_rate, want.mean_rate);
					if (res_if.priming !== want.priming)
						report_mismatch("priming", 32'(res_if.priming), 32'(want.priming));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		logic rdy;
		if (stall_left > 0) begin
			rdy = 1'b0;
			stall_left--;
		end else if (run_left > 0) begin
			rdy = 1'b1;
			run_left--;
		end else begin
			case ($urandom_range(0, 3))
				0: stall_left = 0;
				1: stall_left = $urandom_range(1, 3);
				2: stall_left = $urandom_range(1, 10);
				default: stall_left = $urandom_range(10, 30);
			endcase
			run_left = $urandom_range(1, 40);
			rdy = (stall_left == 0);
		end
		res_if.ready <= rdy;
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_COEF_XX: m_cxx = longint'($signed(data[31:0]));
			REG_COEF_XY: m_cxy = longint'($signed(data[31:0]));
			REG_COEF_YX: m_cyx = longint'($signed(data[31:0]));
			REG_COEF_YY: m_cyy = longint'($signed(data[31:0]));
			REG_FPS: m_fps = data[9:0];
			REG_INV_RADII: m_inv = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every result is in and the block has gone quiet
	task automatic wait_drain();
		det_if.valid <= 1'b0;
		burst_left = 0;
		while (rate_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_det(input logic [15:0] x, input logic [15:0] y,
			input logic [1:0] slot, input logic [15:0] gap, input bit last);
		int idle;
		if (burst_left == 0) begin
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle > 0) begin
				det_if.valid <= 1'b0;
				repeat (idle) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		det_if.valid <= 1'b1;
		det_if.pos_x <= x;
		det_if.pos_y <= y;
		det_if.slot <= slot;
		det_if.frame_gap <= gap;
		det_if.last_in_frame <= last;
		do @(posedge clk); while (!(det_if.valid && det_if.ready));
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return 32'd65536;
			4: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_settings();
		logic [9:0] fps;
		logic [63:0] inv;
		cfg_write(REG_COEF_XX, {32'd0, pick_coef()});
		cfg_write(REG_COEF_XY, {32'd0, pick_coef()});
		cfg_write(REG_OFFSET_X, {$urandom(), $urandom()});
		cfg_write(REG_COEF_YX, {32'd0, pick_coef()});
		cfg_write(REG_COEF_YY, {32'd0, pick_coef()});
		cfg_write(REG_OFFSET_Y, {$urandom(), $urandom()});
		case ($urandom_range(0, 4))
			0: fps = 10'd1;
			1: fps = 10'd1000;
			2: fps = 10'($urandom_range(0, 1023));
			default: fps = 10'($urandom_range(1, 1000));
		endcase
		cfg_write(REG_FPS, {54'd0, fps});
		case ($urandom_range(0, 3))
			0: inv = '1;
			1: inv = {$urandom(), $urandom()} & 64'h00FF_00FF_00FF_00FF;
			default: inv = {$urandom(), $urandom()};
		endcase
		cfg_write(REG_INV_RADII, inv);
	endtask

	task automatic apply_row_cfg(input int sel);
		case (sel)
			CFG_EXTREME: begin
				cfg_write(REG_COEF_XX, 64'h7FFF_FFFF);
				cfg_write(REG_COEF_XY, 64'h8000_0000);
				cfg_write(REG_OFFSET_X, 64'h7FFF_FFFF);
				cfg_write(REG_COEF_YX, 64'h8000_0000);
				cfg_write(REG_COEF_YY, 64'h7FFF_FFFF);
				cfg_write(REG_OFFSET_Y, 64'h8000_0000);
				cfg_write(REG_FPS, 64'd1000);
				cfg_write(REG_INV_RADII, '1);
			end
			CFG_ZERO_FPS: begin
				cfg_write(REG_COEF_XX, 64'd65536);
				cfg_write(REG_COEF_XY, 64'd0);
				cfg_write(REG_COEF_YX, 64'd0);
				cfg_write(REG_COEF_YY, 64'd65536);
				cfg_write(REG_FPS, 64'd0);
			end
			CFG_MIN_FPS: begin
				cfg_write(REG_FPS, 64'd1);
				cfg_write(REG_INV_RADII, 64'h0001_0001_0001_0001);
			end
			default: ;
		endcase
	endtask

	task automatic add_row(input int pc, input logic [15:0] x, input logic [15:0] y,
			input logic [1:0] s, input logic [15:0] g, input bit l, input bit t,
			input logic [31:0] tm, input bit tp);
		det_row_t r;
		r.pre_cfg = pc; r.x = x; r.y = y; r.slot = s; r.gap = g; r.last = l;
		r.typed = t; r.t_mean = tm; r.t_prim = tp;
		dir_rows.push_back(r);
	endtask

	initial begin
		int n, s0, items, noise;
		logic [1:0] s;
		logic [15:0] x, y, g;
		bit l;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		stall_left = 0;
		run_left = 0;
		typed_on = 1'b0;
		typed_mean = '0;
		typed_prim = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		det_if.valid = 1'b0;
		det_if.pos_x = '0;
		det_if.pos_y = '0;
		det_if.slot = '0;
		det_if.frame_gap = '0;
		det_if.last_in_frame = 1'b0;
		res_if.ready = 1'b0;
		m_cxx = 65536; m_cxy = 0; m_cyx = 0; m_cyy = 65536;
		m_fps = 10'd100;
		m_inv = '0;
		for (int k = 0; k < MARKER_COUNT; k++) begin
			trk_x[k] = '0; trk_y[k] = '0; trk_rate[k] = '0;
		end
		trk_primed = 1'b0;

		// priming frame, then one frame with zero radii at reset settings
		add_row(CFG_NONE, 16'h0000, 16'h0000, 2'd0, 16'd0, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'hFFFF, 16'hFFFF, 2'd1, 16'd0, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h0000, 16'hFFFF, 2'd2, 16'd0, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'hFFFF, 16'h0000, 2'd3, 16'd7, 1, 1, 32'd0, 1);
		add_row(CFG_NONE, 16'h0010, 16'h0010, 2'd0, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'hFFF0, 16'hFFF0, 2'd1, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h0020, 16'hFFF0, 2'd2, 16'd2, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'hFFF0, 16'h0020, 2'd3, 16'd1, 1, 1, 32'd0, 0);
		// extreme gains: saturation, zero gap, widest gap
		add_row(CFG_EXTREME, 16'hFFFF, 16'hFFFF, 2'd0, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h0000, 16'h0000, 2'd1, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h8000, 16'h8000, 2'd2, 16'd0, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h7000, 16'h7000, 2'd3, 16'hFFFF, 1, 0, 0, 0);
		// equal distances: own slot keeps the match
		add_row(CFG_NONE, 16'h0100, 16'h0100, 2'd0, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h0300, 16'h0100, 2'd1, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h0200, 16'h0100, 2'd2, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'h0200, 16'h0100, 2'd3, 16'd3, 1, 0, 0, 0);
		add_row(CFG_ZERO_FPS, 16'h1000, 16'h1000, 2'd0, 16'd1, 1, 0, 0, 0);
		add_row(CFG_MIN_FPS, 16'h0000, 16'h0000, 2'd0, 16'd1, 0, 0, 0, 0);
		add_row(CFG_NONE, 16'hFFFF, 16'h0000, 2'd1, 16'd1, 1, 0, 0, 0);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].pre_cfg != CFG_NONE) begin
				wait_drain();
				apply_row_cfg(dir_rows[i].pre_cfg);
			end
			typed_on = dir_rows[i].typed;
			typed_mean = dir_rows[i].t_mean;
			typed_prim = dir_rows[i].t_prim;
			send_det(dir_rows[i].x, dir_rows[i].y, dir_rows[i].slot, dir_rows[i].gap,
				dir_rows[i].last);
		end
		typed_on = 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			random_settings();
			items = 0;
			while (items < PHASE_ITEMS) begin
				if (ph == 0 && items == PHASE_ITEMS / 2)
					wait_drain();
				n = $urandom_range(1, 4);
				s0 = $urandom_range(0, 3);
				case ($urandom_range(0, 9))
					0: g = 16'd0;
					1: g = 16'($urandom());
					default: g = 16'($urandom_range(1, 4));
				endcase
				for (int i = 0; i < n; i++) begin
					s = ($urandom_range(0, 4) == 0) ? 2'($urandom()) : 2'(s0 + i);
					noise = $urandom_range(0, 9);
					if (noise < 8) begin
						x = trk_x[s] + 16'($signed($urandom_range(0, 128)) - 64);
						y = trk_y[s] + 16'($signed($urandom_range(0, 128)) - 64);
					end else begin
						x = 16'($urandom());
						y = 16'($urandom());
					end
					l = (i == n - 1) && ($urandom_range(0, 19) != 0);
					send_det(x, y, s, ($urandom_range(0, 7) == 0) ? 16'($urandom()) : g, l);
					items++;
				end
			end
		end
		send_det(16'h0040, 16'h0040, 2'd0, 16'd1, 1);

		det_if.valid <= 1'b0;
		while (rate_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/mtse_pkg.sv
hw/rtl/mtse_if.sv
hw/rtl/mtse_ctrl.sv
hw/rtl/mtse_datapath.sv
hw/rtl/marker_tracking_speed_estimator_core.sv
tb/marker_tracking_speed_estimator_core_tb.sv
